// ----- hdl/nibble_header_pair_deframer_top_macros.svh -----
// Assertion macros for the nibble header pair deframer.
// NHPD_ASSERT checks a property with reset masking; NHPD_ASSERT_RST
// checks a property across reset as well.
`ifndef NIBBLE_HEADER_PAIR_DEFRAMER_TOP_MACROS_SVH
`define NIBBLE_HEADER_PAIR_DEFRAMER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define NHPD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define NHPD_ASSERT_RST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NHPD_ASSERT(lbl, clk, rst, prop, msg)
`define NHPD_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

// ----- hdl/nhpd_pkg.sv -----
// ----------------------------------------------------------------------------
// nhpd_pkg
// Types and constants shared by the deframer front end, queue and back end.
// ----------------------------------------------------------------------------
package nhpd_pkg;

   localparam logic [3:0] NIB_END      = 4'hF;
   localparam logic [3:0] NIB_NONE     = 4'h0;
   localparam logic [2:0] PAYLOAD_LAST = 3'd7;

   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_FIRST  = 2'd1,
      PH_SECOND = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      OP_HEADER = 2'd0,
      OP_FIRST  = 2'd1,
      OP_SECOND = 2'd2
   } op_type;

   // One classified byte handed from the front end to the back end
   typedef struct packed {
      op_type     op;
      logic [7:0] data;
      logic [2:0] idx;
      logic       emit;
      logic       last;
   } cmd_type;

endpackage

// ----- hdl/nhpd_front.sv -----
// ----------------------------------------------------------------------------
// nhpd_front
// Accepts stream bytes, tracks the header/payload phase and turns each byte
// into a command for the back end.
// ----------------------------------------------------------------------------
`include "nibble_header_pair_deframer_top_macros.svh"

module nhpd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // [7:0] data_byte
   input  logic             fifo_full,
   output logic             push,
   output nhpd_pkg::cmd_type cmd
);

   nhpd_pkg::phase_type phase_ff, phase_in;
   logic [2:0] byte_index_ff, byte_index_in;
   logic       second_ff, second_in;
   logic       end_ff, end_in;

   logic [3:0] hi, lo;
   logic       hi_end, lo_end, hi_zero, lo_zero, idx_last;

   assign hi       = req_tdata[7:4];
   assign lo       = req_tdata[3:0];
   assign hi_end   = (hi == nhpd_pkg::NIB_END);
   assign lo_end   = (lo == nhpd_pkg::NIB_END);
   assign hi_zero  = (hi == nhpd_pkg::NIB_NONE);
   assign lo_zero  = (lo == nhpd_pkg::NIB_NONE);
   assign idx_last = (byte_index_ff == nhpd_pkg::PAYLOAD_LAST);

   assign req_tready = !fifo_full;
   assign push       = req_tvalid && req_tready;

   // next state
   always_comb begin
      phase_in      = phase_ff;
      byte_index_in = byte_index_ff;
      second_in     = second_ff;
      end_in        = end_ff;
      if (push) begin
         case (phase_ff)
            nhpd_pkg::PH_FIRST: begin
               byte_index_in = byte_index_ff + 3'd1;
               if (idx_last) begin
                  if (second_ff) begin
                     phase_in = nhpd_pkg::PH_SECOND;
                  end else begin
                     phase_in = nhpd_pkg::PH_HEADER;
                  end
               end
            end
            nhpd_pkg::PH_SECOND: begin
               byte_index_in = byte_index_ff + 3'd1;
               if (idx_last) begin
                  phase_in = nhpd_pkg::PH_HEADER;
               end
            end
            default: begin
               byte_index_in = 3'd0;
               end_in        = hi_end || lo_end;
               second_in     = !lo_zero && !lo_end && !hi_end;
               if (hi_end) begin
                  phase_in = nhpd_pkg::PH_HEADER;
               end else if (!hi_zero) begin
                  phase_in = nhpd_pkg::PH_FIRST;
               end else if (!lo_zero && !lo_end) begin
                  phase_in = nhpd_pkg::PH_SECOND;
               end else begin
                  phase_in = nhpd_pkg::PH_HEADER;
               end
            end
         endcase
      end
   end

   // command for the back end
   always_comb begin
      cmd.data = req_tdata;
      cmd.idx  = byte_index_ff;
      case (phase_ff)
         nhpd_pkg::PH_FIRST: begin
            cmd.op   = nhpd_pkg::OP_FIRST;
            cmd.emit = idx_last && !second_ff;
            cmd.last = end_ff;
         end
         nhpd_pkg::PH_SECOND: begin
            cmd.op   = nhpd_pkg::OP_SECOND;
            cmd.emit = idx_last;
            cmd.last = end_ff;
         end
         default: begin
            cmd.op   = nhpd_pkg::OP_HEADER;
            cmd.emit = hi_end || (hi_zero && (lo_end || lo_zero));
            cmd.last = hi_end || lo_end;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= nhpd_pkg::PH_HEADER;
         byte_index_ff <= 3'd0;
         second_ff     <= 1'b0;
         end_ff        <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         byte_index_ff <= byte_index_in;
         second_ff     <= second_in;
         end_ff        <= end_in;
      end
   end

   `NHPD_ASSERT(a_header_index_zero, clock, reset,
      (phase_ff == nhpd_pkg::PH_HEADER) |-> (byte_index_ff == 3'd0),
      "byte index not zero while expecting a header")
   `NHPD_ASSERT(a_second_not_ending, clock, reset,
      (phase_ff == nhpd_pkg::PH_SECOND) |-> !(end_ff && second_ff),
      "second payload pending on an ending header")

endmodule

// ----- hdl/nhpd_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// nhpd_cmd_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
`include "nibble_header_pair_deframer_top_macros.svh"

module nhpd_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  nhpd_pkg::cmd_type push_cmd,
   output logic              full,
   output logic              valid,
   input  logic              pop,
   output nhpd_pkg::cmd_type pop_cmd
);

   nhpd_pkg::cmd_type mem_ff [nhpd_pkg::FIFO_DEPTH];

   logic [nhpd_pkg::PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [nhpd_pkg::PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [nhpd_pkg::CNT_W-1:0] count_ff, count_in;
   logic                       do_pop;

   assign full    = (count_ff == nhpd_pkg::CNT_W'(nhpd_pkg::FIFO_DEPTH));
   assign valid   = (count_ff != '0);
   assign pop_cmd = mem_ff[rd_ptr_ff];
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `NHPD_ASSERT(a_no_overflow, clock, reset, push |-> !full,
      "push into a full command queue")
   `NHPD_ASSERT_RST(a_empty_after_reset, clock, reset |=> (count_ff == '0),
      "command queue not empty after reset")

endmodule

// ----- hdl/nhpd_back.sv -----
// ----------------------------------------------------------------------------
// nhpd_back
// Executes commands: latches tags, assembles little-endian payloads and
// loads finished blocks into the result register.
// ----------------------------------------------------------------------------
`include "nibble_header_pair_deframer_top_macros.svh"

module nhpd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  nhpd_pkg::cmd_type cmd,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // [3:0] tag_first, [7:4] tag_second, [71:8] payload_first,
   // [135:72] payload_second
   output logic [135:0]      rsp_tdata,
   output logic              rsp_tlast
);

   logic [7:0]  tags_ff, tags_in;
   logic [63:0] acc1_ff, acc1_in;
   logic [63:0] acc2_ff, acc2_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [135:0] rsp_data_ff, rsp_data_in;
   logic        rsp_last_ff, rsp_last_in;
   logic [5:0]  bit_pos;

   assign pop     = cmd_valid && (!rsp_valid_ff || rsp_tready);
   assign bit_pos = {cmd.idx, 3'b000};

   always_comb begin
      tags_in = tags_ff;
      acc1_in = acc1_ff;
      acc2_in = acc2_ff;
      case (cmd.op)
         nhpd_pkg::OP_FIRST: begin
            acc1_in[bit_pos +: 8] = cmd.data;
         end
         nhpd_pkg::OP_SECOND: begin
            acc2_in[bit_pos +: 8] = cmd.data;
         end
         default: begin
            tags_in = cmd.data;
            acc1_in = '0;
            acc2_in = '0;
         end
      endcase
   end

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      if (pop && cmd.emit) begin
         rsp_data_in  = {acc2_in, acc1_in, tags_in[3:0], tags_in[7:4]};
         rsp_last_in  = cmd.last;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         tags_ff <= tags_in;
         acc1_ff <= acc1_in;
         acc2_ff <= acc2_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   `NHPD_ASSERT(a_pop_only_when_free, clock, reset,
      pop |-> (!rsp_valid_ff || rsp_tready),
      "command taken while result register is blocked")
   `NHPD_ASSERT(a_emit_loads_result, clock, reset,
      (pop && cmd.emit) |=> rsp_valid_ff,
      "emitted block did not reach the result register")

endmodule

// ----- hdl/nibble_header_pair_deframer_top.sv -----
// Path: with the queue empty, a block's final byte is registered in the command queue
// and then in the back end's result register before rsp_tvalid rises.
// Throughput: one byte per cycle while the queue has room; the front end, a 4-entry
// command queue and the back end's result register let each side stall on its own.
// Reset: synchronous, active high; empties the queue and drops any result,
// and the next byte is taken as a header.
// ----------------------------------------------------------------------------
// nibble_header_pair_deframer_top
// Deframes a byte stream of nibble-tag headers and 8-byte payloads into blocks.
// ----------------------------------------------------------------------------
module nibble_header_pair_deframer_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [3:0] tag_first, [7:4] tag_second, [71:8] payload_first,
   // [135:72] payload_second
   output logic [135:0] rsp_tdata,
   output logic         rsp_tlast    // stream_end
);

   nhpd_pkg::cmd_type push_cmd, pop_cmd;
   logic              push, full, cmd_valid, pop;

   nhpd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .fifo_full  (full),
      .push       (push),
      .cmd        (push_cmd)
   );

   nhpd_cmd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (full),
      .valid    (cmd_valid),
      .pop      (pop),
      .pop_cmd  (pop_cmd)
   );

   nhpd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (pop_cmd),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Streams random and directed frames of nibble-tag headers and 8-byte
// payloads into the deframer. Each accepted byte updates a local model of
// the framing state. The blocks it predicts are checked field by field
// against the result channel, under random stalls on both sides and a long
// receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;

   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic       drain;    // wait for every pending block before this beat
      logic [7:0] data;
   } stream_byte_type;

   typedef struct packed {
      logic [3:0]  tag_first;
      logic [3:0]  tag_second;
      logic [63:0] payload_first;
      logic [63:0] payload_second;
      logic        stream_end;
   } deframed_block_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = 8'h00;    // [7:0] data_byte
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // [3:0] tag_first, [7:4] tag_second, [71:8] payload_first,
   // [135:72] payload_second
   logic [135:0] rsp_tdata;
   logic         rsp_tlast;            // stream_end

   stream_byte_type    byte_q[$];
   deframed_block_type block_q[$];
   int              bytes_queued = 0;
   int              mismatch_count = 0;
   int              tx_idle_pct = 0;
   int              rx_idle_pct = 0;
   int              rx_hold_left = 0;
   int              quiet_cycles = 0;

   // framing state of the local model
   nhpd_pkg::phase_type pred_phase = nhpd_pkg::PH_HEADER;
   logic [2:0]  pred_idx = 3'd0;
   logic [7:0]  pred_tags = 8'h00;
   logic [63:0] pred_first = 64'd0;
   logic [63:0] pred_second = 64'd0;
   logic        pred_ending = 1'b0;

   nibble_header_pair_deframer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void emit_block();
      deframed_block_type blk;
      blk.tag_first      = pred_tags[7:4];
      blk.tag_second     = pred_tags[3:0];
      blk.payload_first  = pred_first;
      blk.payload_second = pred_second;
      blk.stream_end     = pred_ending;
      block_q = {block_q, blk};
      pred_phase  = nhpd_pkg::PH_HEADER;
      pred_idx    = 3'd0;
      pred_ending = 1'b0;
   endfunction

   function automatic void deframe_byte(input logic [7:0] b);
      logic [63:0] part;
      if (pred_phase == nhpd_pkg::PH_FIRST || pred_phase == nhpd_pkg::PH_SECOND) begin
         part = 64'(b) << (8 * pred_idx);
         if (pred_phase == nhpd_pkg::PH_FIRST)
            pred_first = pred_first | part;
         else
            pred_second = pred_second | part;
         if (pred_idx != nhpd_pkg::PAYLOAD_LAST) begin
            pred_idx = pred_idx + 3'd1;
            return;
         end
         pred_idx = 3'd0;
         if (pred_phase == nhpd_pkg::PH_FIRST && !pred_ending &&
             pred_tags[3:0] != nhpd_pkg::NIB_NONE) begin
            pred_phase = nhpd_pkg::PH_SECOND;
            return;
         end
         emit_block();
         return;
      end
      // header byte
      pred_tags   = b;
      pred_first  = 64'd0;
      pred_second = 64'd0;
      pred_idx    = 3'd0;
      pred_ending = 1'b0;
      if (b[7:4] == nhpd_pkg::NIB_END) begin
         pred_ending = 1'b1;
         emit_block();
      end else if (b[3:0] == nhpd_pkg::NIB_END) begin
         pred_ending = 1'b1;
         if (b[7:4] != nhpd_pkg::NIB_NONE)
            pred_phase = nhpd_pkg::PH_FIRST;
         else
            emit_block();
      end else if (b[7:4] != nhpd_pkg::NIB_NONE) begin
         pred_phase = nhpd_pkg::PH_FIRST;
      end else if (b[3:0] != nhpd_pkg::NIB_NONE) begin
         pred_phase = nhpd_pkg::PH_SECOND;
      end else begin
         emit_block();
      end
   endfunction

   function automatic void push_byte(input logic [7:0] b, input logic drain);
      stream_byte_type item;
      item.data  = b;
      item.drain = drain;
      byte_q = {byte_q, item};
      bytes_queued++;
   endfunction

   // fill < 0 gives random payload bytes, otherwise every payload byte is fill
   function automatic void queue_frame(input logic [7:0] hdr, input int fill,
                                       input logic drain);
      int n;
      if (hdr[7:4] == nhpd_pkg::NIB_END)
         n = 0;
      else if (hdr[3:0] == nhpd_pkg::NIB_END)
         n = (hdr[7:4] != nhpd_pkg::NIB_NONE) ? 1 : 0;
      else
         n = int'(hdr[7:4] != nhpd_pkg::NIB_NONE) + int'(hdr[3:0] != nhpd_pkg::NIB_NONE);
      push_byte(hdr, drain);
      for (int i = 0; i < 8 * n; i++)
         push_byte((fill < 0) ? 8'($urandom) : 8'(fill), 1'b0);
   endfunction

   function automatic logic [3:0] pick_tag();
      int r;
      r = $urandom_range(99);
      if (r < 20)
         return nhpd_pkg::NIB_NONE;
      if (r < 32)
         return nhpd_pkg::NIB_END;
      return 4'($urandom_range(14, 1));
   endfunction

   // mostly whole frames, now and then a stray byte that shifts the framing
   function automatic void queue_random(input int target);
      while (bytes_queued < target) begin
         if ($urandom_range(99) < 8)
            push_byte(8'($urandom), 1'b0);
         else
            queue_frame({pick_tag(), pick_tag()}, -1, 1'b0);
      end
   endfunction

   task automatic wait_drained();
      while (byte_q.size() != 0 || req_tvalid || block_q.size() != 0)
         @(negedge clock);
   endtask

   function automatic void compare_field(input string name, input logic [63:0] want,
                                         input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // sender
   always @(posedge clock) begin : sender
      stream_byte_type head;
      logic offer;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         offer = 1'b0;
         if (byte_q.size() != 0) begin
            head  = byte_q[0];
            offer = ($urandom_range(99) >= tx_idle_pct);
            // hold until the result channel has caught up
            if (head.drain && (block_q.size() != 0 || req_tvalid))
               offer = 1'b0;
         end
         if (offer) begin
            head = byte_q.pop_front();
            req_tdata <= head.data;
         end
         req_tvalid <= offer;
      end
   end

   // receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rx_hold_left > 0) begin
         rx_hold_left <= rx_hold_left - 1;
         rsp_tready   <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // monitor: check results first, then advance the model on the input beat
   always @(posedge clock) begin : monitor
      deframed_block_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (block_q.size() == 0) begin
               $display("%0t: unexpected block: expected none, got tdata %h tlast %b",
                        $time, rsp_tdata, rsp_tlast);
               mismatch_count++;
            end else begin
               want = block_q.pop_front();
               compare_field("tag_first", 64'(want.tag_first), 64'(rsp_tdata[3:0]));
               compare_field("tag_second", 64'(want.tag_second), 64'(rsp_tdata[7:4]));
               compare_field("payload_first", want.payload_first, rsp_tdata[71:8]);
               compare_field("payload_second", want.payload_second, rsp_tdata[135:72]);
               compare_field("stream_end", 64'(want.stream_end), 64'(rsp_tlast));
            end
         end
         if (req_tvalid && req_tready)
            deframe_byte(req_tdata);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
         $display("** nibble_header_pair_deframer_top: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      tx_idle_pct = 8;
      rx_idle_pct = 62;
      queue_frame(8'h00, 0, 1'b0);       // no payload, no end
      queue_frame(8'hFF, 0, 1'b0);       // both tags end
      queue_frame(8'hF0, 0, 1'b0);       // high end, low empty
      queue_frame(8'hF5, 0, 1'b0);       // high end ignores low tag
      queue_frame(8'h0F, 0, 1'b0);       // low end alone
      queue_frame(8'h3F, 8'hFF, 1'b0);   // low end after one payload
      queue_frame(8'h0E, 8'h00, 1'b0);   // only the second payload
      queue_random(170);
      wait_drained();

      tx_idle_pct = 62;
      rx_idle_pct = 8;
      queue_random(340);
      wait_drained();

      // no idling; stall the receiver long enough to back up the input
      tx_idle_pct  = 0;
      rx_idle_pct  = 0;
      rx_hold_left = HOLD_CYCLES;
      queue_random(420);
      queue_frame({pick_tag(), pick_tag()}, -1, 1'b1);
      queue_random(510);
      wait_drained();

      repeat (10) @(negedge clock);
      if (mismatch_count == 0 && block_q.size() == 0)
         $display("** nibble_header_pair_deframer_top: PASSED **");
      else
         $display("** nibble_header_pair_deframer_top: FAILED **");
      $finish;
   end

endmodule
